@@ rtl/s2x_pkg.sv @@
// ----------------------------------------------------------------------------
// s2x_pkg
// Shared types, constants and blend helpers for the 2x scanline upscaler.
// ----------------------------------------------------------------------------
package s2x_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 1024;
	localparam int StoreDepth = MaxWidth + 1;
	localparam int AddrW  = $clog2(StoreDepth);
	localparam int SizeW  = 11;
	localparam int CoordW = 10;
	localparam int PixW   = 32;

	localparam logic [1:0] FMT_555 = 2'd0;
	localparam logic [1:0] FMT_565 = 2'd1;
	localparam logic [1:0] FMT_32  = 2'd2;

	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [SizeW-1:0] RST_WIDTH  = SizeW'(320);
	localparam logic [SizeW-1:0] RST_HEIGHT = SizeW'(224);

	// source position carried along with each output block
	typedef struct packed {
		logic [CoordW-1:0] col;
		logic [CoordW-1:0] row;
		logic              last;
	} tag_t;

	// pipeline control from the front end
	typedef struct packed {
		logic en;   // pipeline advances
		logic acc;  // input beat taken this cycle
		logic res;  // that beat completes an output block
	} ctl_t;

	function automatic logic [PixW-1:0] mask_half(input logic [1:0] fmt);
		case (fmt)
			FMT_555: mask_half = 32'h0000_3DEF;
			FMT_565: mask_half = 32'h0000_7BEF;
			default: mask_half = 32'h7F7F_7F7F;
		endcase
	endfunction

	function automatic logic [PixW-1:0] mask_quarter(input logic [1:0] fmt);
		case (fmt)
			FMT_555: mask_quarter = 32'h0000_1CE7;
			FMT_565: mask_quarter = 32'h0000_39E7;
			default: mask_quarter = 32'h3F3F_3F3F;
		endcase
	endfunction

	function automatic logic [PixW-1:0] blend2(input logic [PixW-1:0] a,
		input logic [PixW-1:0] b, input logic [PixW-1:0] m2);
		blend2 = ((a >> 1) & m2) + ((b >> 1) & m2);
	endfunction

	// 75% brightness: t/2 + t/4 per channel
	function automatic logic [PixW-1:0] darken(input logic [PixW-1:0] t,
		input logic [PixW-1:0] m2, input logic [PixW-1:0] m4);
		darken = ((t >> 1) & m2) + ((t >> 2) & m4);
	endfunction

endpackage

@@ rtl/s2x_line_store.sv @@
// ----------------------------------------------------------------------------
// s2x_line_store
// Previous-row pixel memory, read-first, one access per accepted pixel.
// ----------------------------------------------------------------------------
module s2x_line_store (
	input  logic                      clk,
	input  logic                      acc,
	input  logic [s2x_pkg::AddrW-1:0] addr,
	input  logic [s2x_pkg::PixW-1:0]  wdata,
	output logic [s2x_pkg::PixW-1:0]  rdata
);
	import s2x_pkg::*;

	logic [PixW-1:0] mem [StoreDepth];
	logic [PixW-1:0] rd_q;

	// old entry comes out while the new pixel replaces it
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q       <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

	assign rdata = rd_q;

endmodule

@@ rtl/s2x_blend.sv @@
// ----------------------------------------------------------------------------
// s2x_blend
// Neighbour registers and the blend/darken pipeline feeding the output reg.
// ----------------------------------------------------------------------------
module s2x_blend (
	input  logic                     clk,
	input  logic                     arst_n,
	input  s2x_pkg::ctl_t            ctl,
	input  logic [1:0]               fmt,
	input  logic [s2x_pkg::PixW-1:0] px,
	input  s2x_pkg::tag_t            tag,
	input  logic [s2x_pkg::PixW-1:0] up,
	output logic                     out_vld,
	output logic [s2x_pkg::PixW-1:0] tl,
	output logic [s2x_pkg::PixW-1:0] tr,
	output logic [s2x_pkg::PixW-1:0] bl,
	output logic [s2x_pkg::PixW-1:0] br,
	output s2x_pkg::tag_t            tag_out
);
	import s2x_pkg::*;

	logic [PixW-1:0] m2, m4;
	logic            itm_s1, res_s1, res_s2, res_s3, vld_q;
	logic [PixW-1:0] upper_left_q, left_q;
	logic [PixW-1:0] px_s1;
	tag_t            tag_s1, tag_s2, tag_s3, tag_q;
	logic [PixW-1:0] c_s2, cr_s2, cd_s2, ddr_s2;
	logic [PixW-1:0] c_s3, cr_s3, cd_s3, four_s3;
	logic [PixW-1:0] tl_q, tr_q, bl_q, br_q;

	assign m2 = mask_half(fmt);
	assign m4 = mask_quarter(fmt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itm_s1       <= 1'b0;
			res_s1       <= 1'b0;
			res_s2       <= 1'b0;
			res_s3       <= 1'b0;
			vld_q        <= 1'b0;
			upper_left_q <= '0;
			left_q       <= '0;
		end else if (ctl.en) begin
			itm_s1 <= ctl.acc;
			res_s1 <= ctl.acc & ctl.res;
			res_s2 <= res_s1;
			res_s3 <= res_s2;
			vld_q  <= res_s3;
			// every pixel shifts the neighbour window, border or not
			if (itm_s1) begin
				upper_left_q <= up;
				left_q       <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			px_s1   <= px;
			tag_s1  <= tag;
			// s2: C, C|R, C|D, D|DR
			c_s2    <= upper_left_q;
			cr_s2   <= blend2(upper_left_q, up, m2);
			cd_s2   <= blend2(upper_left_q, left_q, m2);
			ddr_s2  <= blend2(left_q, px_s1, m2);
			tag_s2  <= tag_s1;
			// s3: four-way blend
			c_s3    <= c_s2;
			cr_s3   <= cr_s2;
			cd_s3   <= cd_s2;
			four_s3 <= blend2(cr_s2, ddr_s2, m2);
			tag_s3  <= tag_s2;
			// output register: scanline darkening on the bottom row
			tl_q    <= c_s3;
			tr_q    <= cr_s3;
			bl_q    <= darken(cd_s3, m2, m4);
			br_q    <= darken(four_s3, m2, m4);
			tag_q   <= tag_s3;
		end
	end

	assign out_vld = vld_q;
	assign tl      = tl_q;
	assign tr      = tr_q;
	assign bl      = bl_q;
	assign br      = br_q;
	assign tag_out = tag_q;

endmodule

@@ rtl/scale2x_interpolate_scanline25.sv @@
// ----------------------------------------------------------------------------
// scale2x_interpolate_scanline25
// 2x bilinear upscaler with 25% scanline darkening on the odd output rows.
// ----------------------------------------------------------------------------
// Usage: send a frame as image_height+1 rows of image_width+1 pixels in
// raster order on the in_* channel; the extra row and column are the right
// and lower neighbours of the last source column and row. Each pixel at
// column >= 1 and row >= 1 produces one beat on out_* carrying the 2x2
// block of source pixel (col-1, row-1); border pixels only update state.
// Throughput is one pixel per clock: the line store is a single-port
// read-first RAM touched once per pixel (read old entry, write new), so no
// two beats ever contend for it. An input beat passes the RAM read, two
// blend stages and the output register on its way to out_*; in_ready only
// drops while a finished block waits on out_ready. The store has no reset
// and no clearing pass; row 0 fills it before any read matters. Writes on
// the cfg channel (any index) restart the frame counters and should be
// done with the pipeline empty. Narrow formats use pixel_in[15:0] only.
// ----------------------------------------------------------------------------
module scale2x_interpolate_scanline25 (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel input
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [s2x_pkg::PixW-1:0]    pixel_in,
	// block output
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [s2x_pkg::PixW-1:0]    top_left,
	output logic [s2x_pkg::PixW-1:0]    top_right,
	output logic [s2x_pkg::PixW-1:0]    bottom_left,
	output logic [s2x_pkg::PixW-1:0]    bottom_right,
	output logic [s2x_pkg::CoordW-1:0]  src_col,
	output logic [s2x_pkg::CoordW-1:0]  src_row,
	output logic                        frame_last,
	// register writes
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [s2x_pkg::SizeW-1:0]   cfg_data
);
	import s2x_pkg::*;

	logic [1:0]       fmt_q;
	logic [SizeW-1:0] width_q, height_q;
	logic [SizeW-1:0] w, h;
	logic [SizeW-1:0] col_q, row_q;
	logic [SizeW-1:0] col_m1, row_m1;
	logic             cfg_wr, acc, en;
	logic [PixW-1:0]  px;
	logic [PixW-1:0]  up;
	tag_t             tag, tag_out;
	ctl_t             ctl;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// stall everything only when the output beat is held
	assign en       = ~out_valid | out_ready;
	assign in_ready = en;
	assign acc      = in_valid & in_ready;

	// saturate sizes to 1..max
	always_comb begin
		if (width_q == '0)                    w = SizeW'(1);
		else if (width_q > SizeW'(MaxWidth))  w = SizeW'(MaxWidth);
		else                                  w = width_q;
		if (height_q == '0)                   h = SizeW'(1);
		else if (height_q > SizeW'(MaxHeight)) h = SizeW'(MaxHeight);
		else                                  h = height_q;
	end

	// narrow formats keep the low half only
	assign px = (fmt_q == FMT_555 || fmt_q == FMT_565) ?
		{16'h0000, pixel_in[15:0]} : pixel_in;

	assign col_m1   = col_q - SizeW'(1);
	assign row_m1   = row_q - SizeW'(1);
	assign tag.col  = col_m1[CoordW-1:0];
	assign tag.row  = row_m1[CoordW-1:0];
	assign tag.last = (col_q == w) && (row_q == h);

	assign ctl.en  = en;
	assign ctl.acc = acc;
	assign ctl.res = (col_q != '0) && (row_q != '0);

	// config registers and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_565;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FORMAT: fmt_q    <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_q >= w) begin
				col_q <= '0;
				row_q <= (row_q >= h) ? '0 : row_q + SizeW'(1);
			end else begin
				col_q <= col_q + SizeW'(1);
			end
		end
	end

	s2x_line_store u_store (
		.clk   (clk),
		.acc   (acc),
		.addr  (col_q[AddrW-1:0]),
		.wdata (px),
		.rdata (up)
	);

	s2x_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.fmt     (fmt_q),
		.px      (px),
		.tag     (tag),
		.up      (up),
		.out_vld (out_valid),
		.tl      (top_left),
		.tr      (top_right),
		.bl      (bottom_left),
		.br      (bottom_right),
		.tag_out (tag_out)
	);

	assign src_col    = tag_out.col;
	assign src_row    = tag_out.row;
	assign frame_last = tag_out.last;

endmodule
